// ===== rtl/lpip_pkg.sv =====
`default_nettype none
package lpip_pkg;

    // default field widths
    localparam int POS_WIDTH_DEFAULT   = 32;
    localparam int SLOPE_WIDTH_DEFAULT = 20;

    // fraction bits of a slope; x and y parts of the cross product are scaled by this
    localparam int SLOPE_FRAC = 16;

endpackage
`default_nettype wire

// ===== rtl/line_pair_impact_parameter_unit.sv =====
`default_nettype none
// Channel   | Ports                                               | Timing
// ----------+-----------------------------------------------------+---------------------------
// request   | start, busy, i_first_*, i_second_*                  | taken when start & !busy
// result    | o_valid, o_signed_distance, o_parallel_flag,        | one-cycle strobe, no stall
//           | o_saturated_flag                                    |
//
// One word may enter every cycle; busy is always low.
// Pipeline, with CW = max(2*SLOPE_WIDTH+1, SLOPE_WIDTH+17):
// 8 front stages (cross product, squares, dot product), CW+1 root stages,
// one range check and POSITION_WIDTH divide stages, two output stages.
// Reset clears only the valid bits; nothing can stall the pipeline.
module line_pair_impact_parameter_unit
    import lpip_pkg::*;
#(
    parameter int POSITION_WIDTH = POS_WIDTH_DEFAULT,
    parameter int SLOPE_WIDTH    = SLOPE_WIDTH_DEFAULT
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire signed [POSITION_WIDTH-1:0]  i_first_x,
    input  wire signed [POSITION_WIDTH-1:0]  i_first_y,
    input  wire signed [POSITION_WIDTH-1:0]  i_first_z,
    input  wire signed [SLOPE_WIDTH-1:0]     i_first_slope_x,
    input  wire signed [SLOPE_WIDTH-1:0]     i_first_slope_y,
    input  wire signed [POSITION_WIDTH-1:0]  i_second_x,
    input  wire signed [POSITION_WIDTH-1:0]  i_second_y,
    input  wire signed [POSITION_WIDTH-1:0]  i_second_z,
    input  wire signed [SLOPE_WIDTH-1:0]     i_second_slope_x,
    input  wire signed [SLOPE_WIDTH-1:0]     i_second_slope_y,
    output logic                             o_valid,
    output logic signed [POSITION_WIDTH-1:0] o_signed_distance,
    output logic                             o_parallel_flag,
    output logic                             o_saturated_flag
);

    localparam int PW  = POSITION_WIDTH;
    localparam int PDW = PW + 1;                    // position difference
    localparam int DW  = SLOPE_WIDTH + 1;           // slope difference
    localparam int PRW = 2 * SLOPE_WIDTH;           // slope product
    localparam int CZW = PRW + 1;                   // z part of cross product
    localparam int CXW = DW + SLOPE_FRAC;           // scaled x/y part
    localparam int CW  = (CZW > CXW) ? CZW : CXW;
    localparam int QW  = 2 * CW + 2;                // squared length
    localparam int SQW = CW + 1;                    // length
    localparam int RW  = SQW + 2;                   // root remainder
    localparam int NW  = PDW + CW + 2;              // dot product
    localparam int ZL  = (CZW + 1) / 2;             // split of |cz|
    localparam int ZU  = CZW - ZL;
    localparam int DL  = (PDW + 1) / 2;             // split of |dz|
    localparam int DU  = PDW - DL;
    localparam int MW  = PDW + CZW;                 // |dz * cz|
    localparam int SXW = 2 * DW + 1;
    localparam int NXW = PDW + DW + 1;

    assign busy = 1'b0;

    // stage 1: differences and slope products
    logic                  r1_vld;
    logic signed [PDW-1:0] r1_dx, r1_dy, r1_dz;
    logic signed [DW-1:0]  r1_dtx, r1_dty;
    logic signed [PRW-1:0] r1_p1, r1_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else          r1_vld <= start;
    end

    always_ff @(posedge i_clk) begin
        r1_dx  <= PDW'(i_first_x) - PDW'(i_second_x);
        r1_dy  <= PDW'(i_first_y) - PDW'(i_second_y);
        r1_dz  <= PDW'(i_first_z) - PDW'(i_second_z);
        r1_dty <= DW'(i_first_slope_y) - DW'(i_second_slope_y);
        r1_dtx <= DW'(i_second_slope_x) - DW'(i_first_slope_x);
        r1_p1  <= PRW'(i_first_slope_x) * PRW'(i_second_slope_y);
        r1_p2  <= PRW'(i_second_slope_x) * PRW'(i_first_slope_y);
    end

    // stage 2: cz, squares of x/y parts, x/y dot terms
    logic                    r2_vld;
    logic signed [CZW-1:0]   r2_cz;
    logic [2*DW-1:0]         r2_sqx, r2_sqy;
    logic signed [NXW-2:0]   r2_mx, r2_my;
    logic signed [PDW-1:0]   r2_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else          r2_vld <= r1_vld;
    end

    always_ff @(posedge i_clk) begin
        r2_cz  <= CZW'(r1_p1) - CZW'(r1_p2);
        r2_sqy <= (2*DW)'(r1_dty) * (2*DW)'(r1_dty);
        r2_sqx <= (2*DW)'(r1_dtx) * (2*DW)'(r1_dtx);
        r2_mx  <= (NXW-1)'(r1_dx) * (NXW-1)'(r1_dty);
        r2_my  <= (NXW-1)'(r1_dy) * (NXW-1)'(r1_dtx);
        r2_dz  <= r1_dz;
    end

    // stage 3: magnitudes, partial sums
    logic                  r3_vld;
    logic                  r3_czneg, r3_pneg;
    logic [CZW-1:0]        r3_czmag;
    logic [PDW-1:0]        r3_dzmag;
    logic [SXW-1:0]        r3_sx;
    logic signed [NXW-1:0] r3_nxy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else          r3_vld <= r2_vld;
    end

    always_ff @(posedge i_clk) begin
        r3_czneg <= r2_cz[CZW-1];
        r3_pneg  <= r2_cz[CZW-1] ^ r2_dz[PDW-1];
        r3_czmag <= r2_cz[CZW-1] ? CZW'(-r2_cz) : CZW'(r2_cz);
        r3_dzmag <= r2_dz[PDW-1] ? PDW'(-r2_dz) : PDW'(r2_dz);
        r3_sx    <= SXW'(r2_sqx) + SXW'(r2_sqy);
        r3_nxy   <= NXW'(r2_mx) + NXW'(r2_my);
    end

    // stage 4: partial products of cz^2 and dz*cz
    logic                  r4_vld;
    logic                  r4_pneg;
    logic [2*ZU-1:0]       r4_zhh;
    logic [ZU+ZL-1:0]      r4_zhl;
    logic [2*ZL-1:0]       r4_zll;
    logic [DU+ZU-1:0]      r4_dhh;
    logic [DU+ZL-1:0]      r4_dhl;
    logic [DL+ZU-1:0]      r4_dlh;
    logic [DL+ZL-1:0]      r4_dll;
    logic [SXW-1:0]        r4_sx;
    logic signed [NXW-1:0] r4_nxy;
    logic [ZU-1:0]         czh;
    logic [ZL-1:0]         czl;
    logic [DU-1:0]         dzh;
    logic [DL-1:0]         dzl;

    assign czh = r3_czmag[CZW-1:ZL];
    assign czl = r3_czmag[ZL-1:0];
    assign dzh = r3_dzmag[PDW-1:DL];
    assign dzl = r3_dzmag[DL-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else          r4_vld <= r3_vld;
    end

    always_ff @(posedge i_clk) begin
        r4_pneg <= r3_pneg;
        r4_zhh  <= (2*ZU)'(czh) * (2*ZU)'(czh);
        r4_zhl  <= (ZU+ZL)'(czh) * (ZU+ZL)'(czl);
        r4_zll  <= (2*ZL)'(czl) * (2*ZL)'(czl);
        r4_dhh  <= (DU+ZU)'(dzh) * (DU+ZU)'(czh);
        r4_dhl  <= (DU+ZL)'(dzh) * (DU+ZL)'(czl);
        r4_dlh  <= (DL+ZU)'(dzl) * (DL+ZU)'(czh);
        r4_dll  <= (DL+ZL)'(dzl) * (DL+ZL)'(czl);
        r4_sx   <= r3_sx;
        r4_nxy  <= r3_nxy;
    end

    // stage 5: assemble cz^2 and |dz*cz|
    logic                  r5_vld;
    logic                  r5_pneg;
    logic [2*CZW-1:0]      r5_cz2;
    logic [MW-1:0]         r5_dzcz;
    logic [SXW-1:0]        r5_sx;
    logic signed [NXW-1:0] r5_nxy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_vld <= 1'b0;
        else          r5_vld <= r4_vld;
    end

    always_ff @(posedge i_clk) begin
        r5_pneg <= r4_pneg;
        r5_cz2  <= ((2*CZW)'(r4_zhh) << (2*ZL)) + ((2*CZW)'(r4_zhl) << (ZL+1))
                 + (2*CZW)'(r4_zll);
        r5_dzcz <= (MW'(r4_dhh) << (DL+ZL)) + (MW'(r4_dhl) << DL)
                 + (MW'(r4_dlh) << ZL) + MW'(r4_dll);
        r5_sx   <= r4_sx;
        r5_nxy  <= r4_nxy;
    end

    // stage 6: squared length, signed z term
    logic                  r6_vld;
    logic [QW-1:0]         r6_q2;
    logic signed [NW-1:0]  r6_dzs;
    logic signed [NXW-1:0] r6_nxy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_vld <= 1'b0;
        else          r6_vld <= r5_vld;
    end

    always_ff @(posedge i_clk) begin
        r6_q2  <= QW'(r5_cz2) + (QW'(r5_sx) << (2*SLOPE_FRAC));
        r6_dzs <= r5_pneg ? -$signed(NW'(r5_dzcz)) : $signed(NW'(r5_dzcz));
        r6_nxy <= r5_nxy;
    end

    // stage 7: dot product
    logic                 r7_vld;
    logic [QW-1:0]        r7_q2;
    logic signed [NW-1:0] r7_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_vld <= 1'b0;
        else          r7_vld <= r6_vld;
    end

    always_ff @(posedge i_clk) begin
        r7_q2 <= r6_q2;
        r7_n  <= (NW'(r6_nxy) <<< SLOPE_FRAC) + r6_dzs;
    end

    // stage 8: sign/magnitude of dot product, parallel check
    logic          r8_vld;
    logic [QW-1:0] r8_q2;
    logic [NW-1:0] r8_nmag;
    logic          r8_nneg, r8_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_vld <= 1'b0;
        else          r8_vld <= r7_vld;
    end

    always_ff @(posedge i_clk) begin
        r8_q2   <= r7_q2;
        r8_nneg <= r7_n[NW-1];
        r8_nmag <= r7_n[NW-1] ? NW'(-r7_n) : NW'(r7_n);
        r8_zero <= (r7_q2 == '0);
    end

    // square root: one result bit per stage
    logic           r_sq_vld  [SQW];
    logic [RW-1:0]  r_sq_rem  [SQW];
    logic [SQW-1:0] r_sq_root [SQW];
    logic [QW-1:0]  r_sq_q2   [SQW];
    logic [NW-1:0]  r_sq_nmag [SQW];
    logic           r_sq_nneg [SQW];
    logic           r_sq_zero [SQW];

    for (genvar i = 0; i < SQW; i++) begin : g_sqrt
        logic           p_vld, p_nneg, p_zero;
        logic [RW-1:0]  p_rem;
        logic [SQW-1:0] p_root;
        logic [QW-1:0]  p_q2;
        logic [NW-1:0]  p_nmag;
        logic [RW+1:0]  cur, trial;
        logic           take;

        if (i == 0) begin : g_first
            assign p_vld  = r8_vld;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_q2   = r8_q2;
            assign p_nmag = r8_nmag;
            assign p_nneg = r8_nneg;
            assign p_zero = r8_zero;
        end else begin : g_next
            assign p_vld  = r_sq_vld[i-1];
            assign p_rem  = r_sq_rem[i-1];
            assign p_root = r_sq_root[i-1];
            assign p_q2   = r_sq_q2[i-1];
            assign p_nmag = r_sq_nmag[i-1];
            assign p_nneg = r_sq_nneg[i-1];
            assign p_zero = r_sq_zero[i-1];
        end

        // bring down two bits, try root*4+1
        assign cur   = {p_rem, p_q2[QW-1:QW-2]};
        assign trial = {(RW-SQW)'(1'b0), p_root, 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_vld[i] <= 1'b0;
            else          r_sq_vld[i] <= p_vld;
        end

        always_ff @(posedge i_clk) begin
            r_sq_rem[i]  <= take ? RW'(cur - trial) : RW'(cur);
            r_sq_root[i] <= {p_root[SQW-2:0], take};
            r_sq_q2[i]   <= p_q2 << 2;
            r_sq_nmag[i] <= p_nmag;
            r_sq_nneg[i] <= p_nneg;
            r_sq_zero[i] <= p_zero;
        end
    end

    // range check: quotient needs more than PW bits
    logic           r_ov_vld;
    logic           r_ov_flag, r_ov_nneg, r_ov_zero;
    logic [SQW-1:0] r_ov_len;
    logic [NW-1:0]  r_ov_nmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov_vld <= 1'b0;
        else          r_ov_vld <= r_sq_vld[SQW-1];
    end

    always_ff @(posedge i_clk) begin
        r_ov_flag <= (r_sq_nmag[SQW-1] >= (NW'(r_sq_root[SQW-1]) << PW));
        r_ov_len  <= r_sq_root[SQW-1];
        r_ov_nmag <= r_sq_nmag[SQW-1];
        r_ov_nneg <= r_sq_nneg[SQW-1];
        r_ov_zero <= r_sq_zero[SQW-1];
    end

    // restoring divide: one quotient bit per stage
    logic           r_dv_vld  [PW];
    logic [SQW-1:0] r_dv_rem  [PW];
    logic [PW-1:0]  r_dv_quo  [PW];
    logic [SQW-1:0] r_dv_len  [PW];
    logic [NW-1:0]  r_dv_nmag [PW];
    logic           r_dv_ov   [PW];
    logic           r_dv_nneg [PW];
    logic           r_dv_zero [PW];

    for (genvar k = 0; k < PW; k++) begin : g_div
        logic           p_vld, p_ov, p_nneg, p_zero;
        logic [SQW-1:0] p_rem, p_len;
        logic [PW-1:0]  p_quo;
        logic [NW-1:0]  p_nmag;
        logic [SQW:0]   cur;
        logic           take;

        if (k == 0) begin : g_first
            assign p_vld  = r_ov_vld;
            assign p_rem  = r_ov_nmag[PW +: SQW];
            assign p_quo  = '0;
            assign p_len  = r_ov_len;
            assign p_nmag = r_ov_nmag;
            assign p_ov   = r_ov_flag;
            assign p_nneg = r_ov_nneg;
            assign p_zero = r_ov_zero;
        end else begin : g_next
            assign p_vld  = r_dv_vld[k-1];
            assign p_rem  = r_dv_rem[k-1];
            assign p_quo  = r_dv_quo[k-1];
            assign p_len  = r_dv_len[k-1];
            assign p_nmag = r_dv_nmag[k-1];
            assign p_ov   = r_dv_ov[k-1];
            assign p_nneg = r_dv_nneg[k-1];
            assign p_zero = r_dv_zero[k-1];
        end

        assign cur  = {p_rem, p_nmag[PW-1-k]};
        assign take = (cur >= {1'b0, p_len});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_vld[k] <= 1'b0;
            else          r_dv_vld[k] <= p_vld;
        end

        always_ff @(posedge i_clk) begin
            r_dv_rem[k]  <= take ? SQW'(cur - {1'b0, p_len}) : SQW'(cur);
            r_dv_quo[k]  <= {p_quo[PW-2:0], take};
            r_dv_len[k]  <= p_len;
            r_dv_nmag[k] <= p_nmag;
            r_dv_ov[k]   <= p_ov;
            r_dv_nneg[k] <= p_nneg;
            r_dv_zero[k] <= p_zero;
        end
    end

    // clip magnitude to the signed position range
    logic          r_st_vld, r_st_sat, r_st_nneg, r_st_zero;
    logic [PW-1:0] r_st_mag;
    logic [PW-1:0] lim;
    logic          sat;

    assign lim = r_dv_nneg[PW-1] ? (PW'(1) << (PW-1)) : ((PW'(1) << (PW-1)) - PW'(1));
    assign sat = r_dv_ov[PW-1] || (r_dv_quo[PW-1] > lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st_vld <= 1'b0;
        else          r_st_vld <= r_dv_vld[PW-1];
    end

    always_ff @(posedge i_clk) begin
        r_st_sat  <= sat;
        r_st_mag  <= sat ? lim : r_dv_quo[PW-1];
        r_st_nneg <= r_dv_nneg[PW-1];
        r_st_zero <= r_dv_zero[PW-1];
    end

    // output word: apply sign, parallel case gives zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_st_vld;
    end

    always_ff @(posedge i_clk) begin
        o_parallel_flag  <= r_st_zero;
        o_saturated_flag <= r_st_sat && !r_st_zero;
        if (r_st_zero) begin
            o_signed_distance <= '0;
        end else begin
            o_signed_distance <= r_st_nneg ? $signed(-r_st_mag) : $signed(r_st_mag);
        end
    end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench;
    import lpip_pkg::*;

    localparam int PW = POS_WIDTH_DEFAULT;
    localparam int SW = SLOPE_WIDTH_DEFAULT;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic signed [PW-1:0] x1, y1, z1, x2, y2, z2;
        logic signed [SW-1:0] tx1, ty1, tx2, ty2;
    } t_pair;

    typedef struct {
        logic signed [PW-1:0] distance;
        logic                 par;
        logic                 sat;
    } t_approach;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [PW-1:0] first_x = '0, first_y = '0, first_z = '0;
    logic signed [PW-1:0] second_x = '0, second_y = '0, second_z = '0;
    logic signed [SW-1:0] first_tx = '0, first_ty = '0, second_tx = '0, second_ty = '0;
    logic o_valid;
    logic signed [PW-1:0] o_signed_distance;
    logic o_parallel_flag;
    logic o_saturated_flag;

    t_approach expected_q[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit gaps_on = 1'b1;
    bit timed_out = 1'b0;

    always #5 i_clk = ~i_clk;

    line_pair_impact_parameter_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_first_x(first_x), .i_first_y(first_y), .i_first_z(first_z),
        .i_first_slope_x(first_tx), .i_first_slope_y(first_ty),
        .i_second_x(second_x), .i_second_y(second_y), .i_second_z(second_z),
        .i_second_slope_x(second_tx), .i_second_slope_y(second_ty),
        .o_valid(o_valid), .o_signed_distance(o_signed_distance),
        .o_parallel_flag(o_parallel_flag), .o_saturated_flag(o_saturated_flag)
    );

    // floor square root of a 128-bit value
    function automatic logic [127:0] floor_sqrt(input logic [127:0] num);
        logic [127:0] res;
        logic [127:0] bitv;
        res = '0;
        bitv = 128'd1 << 126;
        for (int i = 0; i < 64; i++) begin
            if (num >= res + bitv) begin
                num = num - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // closest-approach distance: (P1 - P2) . C / |C|, C = d1 x d2
    function automatic t_approach closest_approach(input t_pair p);
        t_approach r;
        logic signed [127:0] cx, cy, cz, dx, dy, dz, n;
        logic [127:0] len_sq, len, nmag, quo, lim;
        cx = (p.ty1 - p.ty2) <<< SLOPE_FRAC;
        cy = (p.tx2 - p.tx1) <<< SLOPE_FRAC;
        cz = p.tx1 * p.ty2 - p.tx2 * p.ty1;
        dx = p.x1 - p.x2;
        dy = p.y1 - p.y2;
        dz = p.z1 - p.z2;
        len_sq = cx * cx + cy * cy + cz * cz;
        r.distance = '0;
        r.par = 1'b0;
        r.sat = 1'b0;
        if (len_sq == 0) begin
            r.par = 1'b1;
            return r;
        end
        n = dx * cx + dy * cy + dz * cz;
        nmag = (n < 0) ? -n : n;
        len = floor_sqrt(len_sq);
        quo = nmag / len;
        lim = (n < 0) ? (128'd1 << (PW - 1)) : (128'd1 << (PW - 1)) - 1;
        if (quo > lim) begin
            quo = lim;
            r.sat = 1'b1;
        end
        r.distance = (n < 0) ? -quo[PW-1:0] : quo[PW-1:0];
        return r;
    endfunction

    // drive one word and wait until it is taken
    task automatic send_pair(input t_pair p);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        first_x = p.x1; first_y = p.y1; first_z = p.z1;
        first_tx = p.tx1; first_ty = p.ty1;
        second_x = p.x2; second_y = p.y2; second_z = p.z2;
        second_tx = p.tx2; second_ty = p.ty2;
        start = 1'b1;
        while (busy) @(negedge i_clk);
        expected_q = {expected_q, closest_approach(p)};
    endtask

    function automatic t_pair random_pair(input int mode);
        t_pair p;
        p.x1 = $urandom; p.y1 = $urandom; p.z1 = $urandom;
        p.x2 = $urandom; p.y2 = $urandom; p.z2 = $urandom;
        p.tx1 = SW'($urandom); p.ty1 = SW'($urandom);
        p.tx2 = SW'($urandom); p.ty2 = SW'($urandom);
        case (mode)
            // physics-like: small x/y offsets and a shallow x slope
            0: begin
                p.x1 = $signed(p.x1) >>> 12; p.x2 = $signed(p.x2) >>> 12;
                p.y1 = $signed(p.y1) >>> 12; p.y2 = $signed(p.y2) >>> 12;
                p.tx1 = $signed(p.tx1) >>> 4; p.tx2 = $signed(p.tx2) >>> 4;
            end
            // parallel directions
            1: begin p.tx2 = p.tx1; p.ty2 = p.ty1; end
            // nearly parallel
            2: begin p.tx2 = p.tx1 + $signed(SW'($urandom_range(0, 2)) - SW'(1)); p.ty2 = p.ty1; end
            default: ;
        endcase
        return p;
    endfunction

    task automatic test_directed();
        t_pair p;
        t_pair zero;
        zero = '{default: '0};
        // parallel: identical and zero slopes
        send_pair(zero);
        p = zero; p.x1 = 32'sd1600; p.tx1 = 20'sd65536; p.tx2 = 20'sd65536;
        send_pair(p);
        // perpendicular unit lines, small offset either sign
        p = zero; p.tx1 = 20'sd65536; p.ty2 = 20'sd65536; p.y1 = 32'sd160;
        send_pair(p);
        p.y1 = -32'sd160;
        send_pair(p);
        // saturation both ways
        p = zero; p.ty1 = 20'sd65536; p.tx2 = 20'sd65536;
        p.z1 = {1'b0, {(PW-1){1'b1}}}; p.z2 = {1'b1, {(PW-1){1'b0}}};
        send_pair(p);
        p.z1 = {1'b1, {(PW-1){1'b0}}}; p.z2 = {1'b0, {(PW-1){1'b1}}};
        send_pair(p);
        // extreme slopes and positions
        for (int i = 0; i < 16; i++) begin
            p.x1 = i[0] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
            p.y1 = -p.x1; p.z1 = p.x1; p.x2 = -p.x1; p.y2 = p.x1; p.z2 = p.y1;
            p.tx1 = i[1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            p.ty1 = i[2] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            p.tx2 = i[3] ? -p.tx1 : 20'sd1;
            p.ty2 = i[0] ? p.ty1 : -20'sd1;
            send_pair(p);
        end
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_pair(random_pair($urandom_range(0, 5)));
    endtask

    task automatic test_back_to_back(input int count);
        gaps_on = 1'b0;
        for (int i = 0; i < count; i++)
            send_pair(random_pair($urandom_range(0, 5)));
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_approach e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: distance=%0d", o_signed_distance);
            end else begin
                e = expected_q.pop_front();
                if (o_signed_distance !== e.distance || o_parallel_flag !== e.par
                        || o_saturated_flag !== e.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: distance %0d/%0d par %b/%b sat %b/%b (exp/got)",
                                 e.distance, o_signed_distance, e.par, o_parallel_flag,
                                 e.sat, o_saturated_flag);
                end
            end
        end
    end

    // watchdog on cycles with no accepted word either way
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(880);
        test_back_to_back(120);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
